FILE: rtl/union_find_rank_compress_defines.svh
// assertion macros for the disjoint-set engine
`ifndef UNION_FIND_RANK_COMPRESS_DEFINES_SVH
`define UNION_FIND_RANK_COMPRESS_DEFINES_SVH

`ifndef SYNTHESIS

// plain check, sampled on the rising clock, off while reset is held
`define UFRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("union_find_rank_compress: check failed");

// implication check, same clocking and reset as above
`define UFRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("union_find_rank_compress: implication failed");

// next-cycle check, same clocking and reset as above
`define UFRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("union_find_rank_compress: next-cycle check failed");

`else

`define UFRC_ASSERT(lbl, prop)
`define UFRC_ASSERT_IMP(lbl, ante, cons)
`define UFRC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/ufrc_pkg.sv
`default_nettype none

package ufrc_pkg;

  localparam int NodesDefault = 1024;
  localparam int NodeW        = 10;
  localparam int RankW        = 4;

  localparam logic [RankW-1:0] RankMax        = 4'd15;
  localparam logic [NodeW-1:0] NodeCountReset = 10'd1023;

  // operation codes
  localparam logic KindUnion = 1'b0;
  localparam logic KindFind  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } req_t;

  typedef struct packed {
    logic [NodeW-1:0] root_a;
    logic [NodeW-1:0] root_b;
    logic             same_set;
    logic             error;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_RANK_A,
    ST_RANK_B,
    ST_LINK,
    ST_RESP
  } ufrc_state_e;

endpackage

`default_nettype wire

FILE: rtl/union_find_rank_compress.sv
`default_nettype none

// Disjoint-set engine, union by rank with full path compression. An item is taken
// when start_i is high and busy_o is low; its single result appears on rsp_o for one
// cycle with done_o high and cannot be held off, so the receiver must take it then.
// After reset the block sweeps both tables (parent to own index, rank to zero), one
// entry a cycle, with busy_o high; node_count writes are taken at any time. A find
// walks from its node up to the root on the single read port of the parent memory
// (a read and a check state per link walked), then points every link on the path
// at the root (a read and a write state per link), node_a first and then node_b; a
// union whose roots differ then reads both ranks on the rank memory port and links
// the roots; a result state follows. A transaction with a bad node index answers in the next cycle.
module union_find_rank_compress #(
  parameter int NODES = ufrc_pkg::NodesDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ufrc_pkg::NodeW-1:0]  cfg_wdata_i,
  input  wire logic                        start_i,
  input  wire ufrc_pkg::req_t              req_i,
  output logic                             busy_o,
  output logic                             done_o,
  output ufrc_pkg::rsp_t                   rsp_o
);

  // node index width inside the tables, and a step count that can reach NODES
  localparam int IdxW = $clog2(NODES);
  localparam int CntW = IdxW + 1;
  localparam logic [CntW-1:0] NodesCnt = CntW'(NODES);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(NODES - 1);

  ufrc_pkg::ufrc_state_e state_q, state_d;

  logic [ufrc_pkg::NodeW-1:0] node_count_q;
  logic [IdxW-1:0]            clr_q;

  // transaction and walk registers
  logic                       kind_q;
  logic                       err_q;
  logic                       side_q;   // low while working on node_a
  logic [IdxW-1:0]            node_a_q;
  logic [IdxW-1:0]            node_b_q;
  logic [IdxW-1:0]            cur_q;
  logic [CntW-1:0]            step_q;
  logic [IdxW-1:0]            ra_q;
  logic [IdxW-1:0]            rb_q;
  logic [ufrc_pkg::RankW-1:0] rank_a_q;

  // memory ports
  logic                       par_we, par_re;
  logic [IdxW-1:0]            par_waddr, par_raddr, par_wdata, par_rdata;
  logic                       rnk_we, rnk_re;
  logic [IdxW-1:0]            rnk_waddr, rnk_raddr;
  logic [ufrc_pkg::RankW-1:0] rnk_wdata, rnk_rdata;

  logic                       accept;
  logic                       a_ok, b_ok;
  logic [IdxW-1:0]            root_cur;
  logic [IdxW-1:0]            start_cur;
  logic                       up_out;
  logic                       walk_limit;
  logic                       walk_root;
  logic                       comp_end;
  logic                       find_end;
  logic                       link_needed;
  logic [ufrc_pkg::RankW-1:0] rank_inc;

  assign accept = start_i && !busy_o;

  // a node is usable only if nonzero, within node_count and inside the tables
  assign a_ok = (req_i.node_a != '0) && (req_i.node_a <= node_count_q) &&
                (32'(req_i.node_a) < NODES);
  assign b_ok = (req_i.node_b != '0) && (req_i.node_b <= node_count_q) &&
                (32'(req_i.node_b) < NODES);

  assign root_cur  = side_q ? rb_q : ra_q;
  assign start_cur = side_q ? node_b_q : node_a_q;

  // a link pointing outside the tables counts as a root
  assign up_out     = CntW'(par_rdata) >= NodesCnt;
  assign walk_limit = step_q == NodesCnt;
  assign walk_root  = (par_rdata == cur_q) || up_out;
  assign comp_end   = (cur_q == root_cur) || walk_limit;

  // end of path rewriting for the current node
  assign find_end = ((state_q == ufrc_pkg::ST_COMP_RD) && comp_end) ||
                    ((state_q == ufrc_pkg::ST_COMP_WR) && up_out);

  assign link_needed = (kind_q == ufrc_pkg::KindUnion) && (ra_q != rb_q);

  // rank saturates at its top value
  assign rank_inc = (rank_a_q == ufrc_pkg::RankMax) ? rank_a_q :
                    rank_a_q + ufrc_pkg::RankW'(1);

  ufrc_ram #(
    .Depth (NODES),
    .Width (IdxW)
  ) u_parent (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .re_i    (par_re),
    .raddr_i (par_raddr),
    .rdata_o (par_rdata)
  );

  ufrc_ram #(
    .Depth (NODES),
    .Width (ufrc_pkg::RankW)
  ) u_rank (
    .clk_i   (clk_i),
    .we_i    (rnk_we),
    .waddr_i (rnk_waddr),
    .wdata_i (rnk_wdata),
    .re_i    (rnk_re),
    .raddr_i (rnk_raddr),
    .rdata_o (rnk_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      ufrc_pkg::ST_INIT: begin
        if (clr_q == LastIdx) state_d = ufrc_pkg::ST_IDLE;
      end
      ufrc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (a_ok && b_ok) ? ufrc_pkg::ST_WALK_RD : ufrc_pkg::ST_RESP;
        end
      end
      ufrc_pkg::ST_WALK_RD: begin
        state_d = walk_limit ? ufrc_pkg::ST_COMP_RD : ufrc_pkg::ST_WALK_CHK;
      end
      ufrc_pkg::ST_WALK_CHK: begin
        state_d = walk_root ? ufrc_pkg::ST_COMP_RD : ufrc_pkg::ST_WALK_RD;
      end
      ufrc_pkg::ST_COMP_RD, ufrc_pkg::ST_COMP_WR: begin
        if (find_end) begin
          if (!side_q)          state_d = ufrc_pkg::ST_WALK_RD;
          else if (link_needed) state_d = ufrc_pkg::ST_RANK_A;
          else                  state_d = ufrc_pkg::ST_RESP;
        end else if (state_q == ufrc_pkg::ST_COMP_RD) begin
          state_d = ufrc_pkg::ST_COMP_WR;
        end else begin
          state_d = ufrc_pkg::ST_COMP_RD;
        end
      end
      ufrc_pkg::ST_RANK_A: state_d = ufrc_pkg::ST_RANK_B;
      ufrc_pkg::ST_RANK_B: state_d = ufrc_pkg::ST_LINK;
      ufrc_pkg::ST_LINK:   state_d = ufrc_pkg::ST_RESP;
      ufrc_pkg::ST_RESP:   state_d = ufrc_pkg::ST_IDLE;
      default:             state_d = ufrc_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy_o    = 1'b1;
    done_o    = 1'b0;
    par_we    = 1'b0;
    par_waddr = cur_q;
    par_wdata = root_cur;
    par_re    = 1'b0;
    par_raddr = cur_q;
    rnk_we    = 1'b0;
    rnk_waddr = ra_q;
    rnk_wdata = rank_inc;
    rnk_re    = 1'b0;
    rnk_raddr = ra_q;
    unique case (state_q)
      ufrc_pkg::ST_INIT: begin
        // clearing sweep: own index, rank zero
        par_we    = 1'b1;
        par_waddr = clr_q;
        par_wdata = clr_q;
        rnk_we    = 1'b1;
        rnk_waddr = clr_q;
        rnk_wdata = '0;
      end
      ufrc_pkg::ST_IDLE: begin
        busy_o = 1'b0;
      end
      ufrc_pkg::ST_WALK_RD: begin
        par_re = !walk_limit;
      end
      ufrc_pkg::ST_WALK_CHK: begin
      end
      ufrc_pkg::ST_COMP_RD: begin
        par_re = !comp_end;
      end
      ufrc_pkg::ST_COMP_WR: begin
        // point the node straight at its root
        par_we = 1'b1;
      end
      ufrc_pkg::ST_RANK_A: begin
        rnk_re = 1'b1;
      end
      ufrc_pkg::ST_RANK_B: begin
        rnk_re    = 1'b1;
        rnk_raddr = rb_q;
      end
      ufrc_pkg::ST_LINK: begin
        // rnk_rdata holds the rank of root b here
        par_we = 1'b1;
        if (rank_a_q < rnk_rdata) begin
          par_waddr = ra_q;
          par_wdata = rb_q;
        end else begin
          par_waddr = rb_q;
          par_wdata = ra_q;
          rnk_we    = rank_a_q == rnk_rdata;
        end
      end
      ufrc_pkg::ST_RESP: begin
        done_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ufrc_pkg::ST_INIT;
      clr_q        <= '0;
      node_count_q <= ufrc_pkg::NodeCountReset;
    end else begin
      state_q <= state_d;
      if (state_q == ufrc_pkg::ST_INIT) clr_q <= clr_q + IdxW'(1);
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
    end
  end

  // transaction and walk datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q) inside
      ufrc_pkg::ST_IDLE: begin
        if (accept) begin
          kind_q   <= req_i.kind;
          err_q    <= !(a_ok && b_ok);
          node_a_q <= IdxW'(req_i.node_a);
          node_b_q <= IdxW'(req_i.node_b);
          cur_q    <= IdxW'(req_i.node_a);
          side_q   <= 1'b0;
          step_q   <= '0;
          ra_q     <= '0;
          rb_q     <= '0;
        end
      end
      ufrc_pkg::ST_WALK_RD, ufrc_pkg::ST_WALK_CHK: begin
        if ((state_q == ufrc_pkg::ST_WALK_RD && walk_limit) ||
            (state_q == ufrc_pkg::ST_WALK_CHK && walk_root)) begin
          // root found, restart from the node for rewriting
          if (side_q) rb_q <= cur_q;
          else        ra_q <= cur_q;
          cur_q  <= start_cur;
          step_q <= '0;
        end else if (state_q == ufrc_pkg::ST_WALK_CHK) begin
          cur_q  <= par_rdata;
          step_q <= step_q + CntW'(1);
        end
      end
      ufrc_pkg::ST_COMP_RD, ufrc_pkg::ST_COMP_WR: begin
        if (find_end) begin
          if (!side_q) begin
            side_q <= 1'b1;
            cur_q  <= node_b_q;
            step_q <= '0;
          end
        end else if (state_q == ufrc_pkg::ST_COMP_WR) begin
          cur_q  <= par_rdata;
          step_q <= step_q + CntW'(1);
        end
      end
      ufrc_pkg::ST_RANK_B: begin
        rank_a_q <= rnk_rdata;
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.root_a   = err_q ? '0 : ufrc_pkg::NodeW'(ra_q);
  assign rsp_o.root_b   = err_q ? '0 : ufrc_pkg::NodeW'(rb_q);
  assign rsp_o.same_set = !err_q && (ra_q == rb_q);
  assign rsp_o.error    = err_q;

`include "union_find_rank_compress_defines.svh"

  // one result per transaction: done_o never stays high, and the block goes idle right after it
  `UFRC_ASSERT_NEXT(a_single_done, done_o, !done_o && !busy_o)
  // an accepted transaction keeps the block busy next cycle
  `UFRC_ASSERT_NEXT(a_accept_busy, accept, busy_o)
  // roots are linked only for a union of two distinct sets
  `UFRC_ASSERT_IMP(a_link_union, state_q == ufrc_pkg::ST_LINK, kind_q == ufrc_pkg::KindUnion && ra_q != rb_q)
  // a rejected transaction reports no roots
  `UFRC_ASSERT_IMP(a_err_clean, done_o && rsp_o.error, rsp_o.root_a == '0 && rsp_o.root_b == '0 && !rsp_o.same_set)
  // path rewriting never runs past the step bound
  `UFRC_ASSERT_IMP(a_step_bound, state_q == ufrc_pkg::ST_COMP_WR, step_q < NodesCnt)

endmodule

`default_nettype wire

FILE: rtl/ufrc_ram.sv
`default_nettype none

// one write port, one read port, registered read data
module ufrc_ram #(
  parameter int Depth = 1024,
  parameter int Width = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ufrc_pkg::*;

  localparam int Nodes      = NodesDefault;
  localparam int CycleLimit = 400000;
  // worst walk here is about ten links per node, both nodes, plus the rank step
  localparam int TailCycles = 200;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [NodeW-1:0] cfg_wdata_i;
  logic             start_i;
  req_t             req_i;
  logic             busy_o;
  logic             done_o;
  rsp_t             rsp_o;

  // mirror of the block's tables and register
  logic [NodeW-1:0] link_mirror [Nodes];
  logic [RankW-1:0] rank_mirror [Nodes];
  logic [NodeW-1:0] live_nodes;

  rsp_t        rsp_due_q[$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  bit          gapless;

  union_find_rank_compress #(
    .NODES (Nodes)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_live(logic [NodeW-1:0] n);
    return (n != '0) && (n <= live_nodes);
  endfunction

  // follow parent links up to the root, bounded against a looping table
  function automatic logic [NodeW-1:0] trace_root(logic [NodeW-1:0] n);
    logic [NodeW-1:0] cur;
    int               steps;
    cur   = n;
    steps = 0;
    while (steps < Nodes && link_mirror[cur] != cur) begin
      cur = link_mirror[cur];
      steps++;
    end
    return cur;
  endfunction

  // point every node on the walked path straight at the root
  function automatic logic [NodeW-1:0] flatten_path(logic [NodeW-1:0] n);
    logic [NodeW-1:0] root;
    logic [NodeW-1:0] cur;
    logic [NodeW-1:0] nxt;
    int               steps;
    root  = trace_root(n);
    cur   = n;
    steps = 0;
    while (cur != root && steps < Nodes) begin
      nxt              = link_mirror[cur];
      link_mirror[cur] = root;
      cur              = nxt;
      steps++;
    end
    return root;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t             res;
    logic [NodeW-1:0] ra;
    logic [NodeW-1:0] rb;
    res = '0;
    if (!is_live(r.node_a) || !is_live(r.node_b)) begin
      res.error = 1'b1;
      return res;
    end
    // node_a is walked and compressed before node_b
    ra           = flatten_path(r.node_a);
    rb           = flatten_path(r.node_b);
    res.root_a   = ra;
    res.root_b   = rb;
    res.same_set = (ra == rb);
    if (r.kind == KindUnion && ra != rb) begin
      if (rank_mirror[ra] < rank_mirror[rb]) begin
        link_mirror[ra] = rb;
      end else if (rank_mirror[ra] > rank_mirror[rb]) begin
        link_mirror[rb] = ra;
      end else begin
        // tie: first root wins and its rank rises, saturating
        link_mirror[rb] = ra;
        if (rank_mirror[ra] != RankMax) rank_mirror[ra] = rank_mirror[ra] + 1'b1;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // checking and run limit
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("error at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (rsp_due_q.size() == 0) begin
        report_mismatch($sformatf("result with no transaction outstanding: %p", rsp_o));
      end else begin
        if (rsp_o.root_a !== rsp_due_q[0].root_a)
          report_mismatch($sformatf("root_a got %0d expected %0d",
                                    rsp_o.root_a, rsp_due_q[0].root_a));
        if (rsp_o.root_b !== rsp_due_q[0].root_b)
          report_mismatch($sformatf("root_b got %0d expected %0d",
                                    rsp_o.root_b, rsp_due_q[0].root_b));
        if (rsp_o.same_set !== rsp_due_q[0].same_set)
          report_mismatch($sformatf("same_set got %b expected %b",
                                    rsp_o.same_set, rsp_due_q[0].same_set));
        if (rsp_o.error !== rsp_due_q[0].error)
          report_mismatch($sformatf("error got %b expected %b",
                                    rsp_o.error, rsp_due_q[0].error));
        void'(rsp_due_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, rsp_due_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  function automatic int idle_gap();
    return gapless ? 0 : $urandom_range(0, 6);
  endfunction

  // start_i stays high between back-to-back transactions; it drops only for a gap or a drain
  task automatic issue_request(logic kind, logic [NodeW-1:0] a, logic [NodeW-1:0] b,
                               int gap);
    req_t r;
    r.kind   = kind;
    r.node_a = a;
    r.node_b = b;
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    // accepted at this edge
    rsp_due_q.push_back(apply_request(r));
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (rsp_due_q.size() != 0) @(posedge clk_i);
  endtask

  // only written with the engine idle
  task automatic write_node_count(logic [NodeW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    live_nodes   = v;
  endtask

  function automatic logic [NodeW-1:0] pick_node();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 85 && live_nodes != '0) return NodeW'($urandom_range(1, live_nodes));
    if (sel < 92) return '0;
    if (live_nodes < NodeCountReset) return NodeW'($urandom_range(live_nodes + 1, 1023));
    return NodeW'($urandom_range(0, 1023));
  endfunction

  function automatic logic pick_kind();
    return ($urandom_range(0, 1) != 0) ? KindFind : KindUnion;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked transactions straight after reset, node_count at its reset value
  task automatic test_directed();
    issue_request(KindFind,  10'd1,    10'd2,    idle_gap()); // two singletons
    issue_request(KindUnion, 10'd1,    10'd2,    idle_gap()); // tie, node 1 rises
    issue_request(KindUnion, 10'd2,    10'd1,    idle_gap()); // same roots, no change
    issue_request(KindUnion, 10'd3,    10'd4,    idle_gap());
    issue_request(KindUnion, 10'd4,    10'd2,    idle_gap()); // tie at rank one
    issue_request(KindFind,  10'd2,    10'd4,    idle_gap()); // compresses node 2
    issue_request(KindUnion, 10'd5,    10'd1,    idle_gap()); // lower rank goes under
    issue_request(KindUnion, 10'd1023, 10'd1,    idle_gap()); // top node
    issue_request(KindFind,  10'd1023, 10'd1022, idle_gap());
    issue_request(KindFind,  10'd1022, 10'd5,    idle_gap()); // find never merges
    issue_request(KindUnion, 10'd1022, 10'd1022, idle_gap());
    issue_request(KindUnion, 10'd0,    10'd5,    idle_gap()); // bad first node
    issue_request(KindUnion, 10'd5,    10'd0,    idle_gap()); // bad second node
    issue_request(KindFind,  10'd0,    10'd0,    idle_gap());
    issue_request(KindFind,  10'd1,    10'd1,    idle_gap());
  endtask

  // a single node in use: everything else is out of range
  task automatic test_single_node();
    write_node_count(10'd1);
    issue_request(KindFind,  10'd1,    10'd1, idle_gap());
    issue_request(KindUnion, 10'd1,    10'd1, idle_gap());
    issue_request(KindFind,  10'd1,    10'd2, idle_gap());
    issue_request(KindUnion, 10'd2,    10'd1, idle_gap());
    issue_request(KindUnion, 10'd1023, 10'd1, idle_gap());
  endtask

  // node_count of zero: no node is valid
  task automatic test_no_nodes();
    write_node_count(10'd0);
    issue_request(KindUnion, 10'd1,    10'd1,    idle_gap());
    issue_request(KindFind,  10'd1023, 10'd1023, idle_gap());
    issue_request(KindFind,  10'd0,    10'd1,    idle_gap());
  endtask

  // binomial trees over a fresh block of nodes: ranks climb and paths get long
  task automatic test_rank_build(int log_size);
    int               size;
    int               base;
    logic [NodeW-1:0] a;
    logic [NodeW-1:0] b;
    size = 1 << log_size;
    base = $urandom_range(64, 1021 - size);
    write_node_count(NodeCountReset);
    for (int s = 1; s < size; s = s * 2) begin
      for (int i = 0; i < size; i = i + 2 * s) begin
        a = NodeW'(base + i);
        b = NodeW'(base + i + s);
        // either order: on a tie the first root takes over
        if ($urandom_range(0, 1) != 0) issue_request(KindUnion, a, b, idle_gap());
        else issue_request(KindUnion, b, a, idle_gap());
      end
    end
    for (int i = 0; i < 6; i++)
      issue_request(KindFind, NodeW'(base + $urandom_range(0, size - 1)),
                    NodeW'(base + $urandom_range(0, size - 1)), idle_gap());
  endtask

  // random transactions under one node_count
  task automatic test_random(logic [NodeW-1:0] count, int items);
    write_node_count(count);
    for (int i = 0; i < items; i++) begin
      if (i % 16 == 0) gapless = ($urandom_range(0, 3) == 0);
      // now and then the sender waits for every result to come back
      if ($urandom_range(0, 39) == 0) drain();
      issue_request(pick_kind(), pick_node(), pick_node(), idle_gap());
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    start_i     = 1'b0;
    req_i       = '0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    gapless     = 1'b0;
    live_nodes  = NodeCountReset;
    for (int i = 0; i < Nodes; i++) begin
      link_mirror[i] = NodeW'(i);
      rank_mirror[i] = '0;
    end
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // the table sweep after reset holds busy_o; issue_request just waits it out
    test_directed();
    test_rank_build(7);
    test_single_node();
    test_no_nodes();
    test_random(NodeCountReset, 80);
    test_random(10'd40, 120);
    test_random(10'd3, 30);
    test_random(10'd700, 40);
    test_random(NodeCountReset, 80);

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
